// File: hdl/prarq_pkg.sv
// Package for the partial-reliability ARQ sender: event codes, result codes,
// register reset value and the result record passed between the core and the output stage.
// No dependencies.
`default_nettype none

package prarq_pkg;

    // event codes on the kind field
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam int ACTION_W = 3;
    localparam int LOST_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_IGNORED    = 3'd0,
        ACT_TRANSMIT   = 3'd1,
        ACT_RETRANSMIT = 3'd2,
        ACT_ACKED      = 3'd3,
        ACT_TOLERATED  = 3'd4,
        ACT_WRONG_ACK  = 3'd5
    } action_t;

    // floor(0.3 * 16) lost slots tolerated after reset
    localparam logic [LOST_W-1:0] MAX_LOST_RESET = 5'd4;

    typedef struct packed {
        action_t           action;
        logic              seq;
        logic [LOST_W-1:0] lost;
    } result_t;

endpackage : prarq_pkg

`default_nettype wire

// File: hdl/prarq_core.sv
// Protocol state and single-pass event decision for the ARQ sender.
// Depends on prarq_pkg.
`default_nettype none

module prarq_core #(
    parameter int WINDOW = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [prarq_pkg::LOST_W-1:0] cfg_wdata,
    input  wire logic                        fire,
    input  wire logic [1:0]                  kind,
    input  wire logic                        ack_flag,
    input  wire logic                        ack_seq,
    output prarq_pkg::result_t               res
);
    import prarq_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = (CNT_W > LOST_W) ? CNT_W : LOST_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [LOST_W-1:0] max_lost_reg;
    logic              next_seq_reg, next_seq_next;
    logic              tx_seq_reg, tx_seq_next;
    logic              waiting_reg, waiting_next;
    logic [WINDOW-1:0] window_reg, window_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  lost_reg, lost_next;

    logic              slot_ok;
    logic [SLOT_W-1:0] slot_inc;
    logic [CNT_W-1:0]  lost_if_lost;
    logic [CMP_W-1:0]  lost_cmp;
    logic [CMP_W-1:0]  lost_out;
    action_t           action;
    logic              seq;

    assign slot_ok      = window_reg[slot_reg];
    assign slot_inc     = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    // count after marking the current slot lost
    assign lost_if_lost = slot_ok ? lost_reg + 1'b1 : lost_reg;
    assign lost_cmp     = CMP_W'(lost_if_lost);

    always_comb
    begin
        next_seq_next = next_seq_reg;
        tx_seq_next   = tx_seq_reg;
        waiting_next  = waiting_reg;
        window_next   = window_reg;
        slot_next     = slot_reg;
        lost_next     = lost_reg;
        action        = ACT_IGNORED;
        seq           = 1'b0;
        case (kind)
            KIND_SEND:
            begin
                if (!waiting_reg)
                begin
                    tx_seq_next   = next_seq_reg;
                    next_seq_next = ~next_seq_reg;
                    waiting_next  = 1'b1;
                    action        = ACT_TRANSMIT;
                    seq           = next_seq_reg;
                end
            end
            KIND_ACK:
            begin
                if (waiting_reg)
                begin
                    if (ack_flag && (ack_seq == next_seq_reg))
                    begin
                        window_next[slot_reg] = 1'b1;
                        lost_next    = slot_ok ? lost_reg : lost_reg - 1'b1;
                        slot_next    = slot_inc;
                        waiting_next = 1'b0;
                        action       = ACT_ACKED;
                    end
                    else
                    begin
                        action = ACT_WRONG_ACK;
                    end
                end
            end
            KIND_TIMEOUT:
            begin
                if (waiting_reg)
                begin
                    window_next[slot_reg] = 1'b0;
                    lost_next = lost_if_lost;
                    if (lost_cmp <= CMP_W'(max_lost_reg))
                    begin
                        slot_next     = slot_inc;
                        next_seq_next = ~next_seq_reg;
                        waiting_next  = 1'b0;
                        action        = ACT_TOLERATED;
                    end
                    else
                    begin
                        action = ACT_RETRANSMIT;
                        seq    = tx_seq_reg;
                    end
                end
            end
            default:
            begin
                action = ACT_IGNORED;
            end
        endcase
    end

    // saturate the reported count at the field's top value
    assign lost_out   = CMP_W'(lost_next);
    assign res.action = action;
    assign res.seq    = seq;
    assign res.lost   = (lost_out > CMP_W'(31)) ? 5'd31 : lost_out[LOST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lost_reg <= MAX_LOST_RESET;
            next_seq_reg <= 1'b0;
            tx_seq_reg   <= 1'b0;
            waiting_reg  <= 1'b0;
            window_reg   <= '1;
            slot_reg     <= '0;
            lost_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_lost_reg <= cfg_wdata;
            end
            if (fire)
            begin
                next_seq_reg <= next_seq_next;
                tx_seq_reg   <= tx_seq_next;
                waiting_reg  <= waiting_next;
                window_reg   <= window_next;
                slot_reg     <= slot_next;
                lost_reg     <= lost_next;
            end
        end
    end

endmodule : prarq_core

`default_nettype wire

// File: hdl/prarq_outreg.sv
// Result register for the ARQ sender: holds one result beat until the receiver takes it.
// Depends on prarq_pkg.
`default_nettype none

module prarq_outreg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  prarq_pkg::result_t res_in,
    output logic               can_load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output prarq_pkg::result_t res_out
);
    import prarq_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= res_in;
        end
    end

endmodule : prarq_outreg

`default_nettype wire

// File: hdl/partial_reliability_arq_sender_unit.sv
// Top level of the partial-reliability stop-and-wait ARQ sender.
// Depends on prarq_pkg, prarq_core and prarq_outreg.
//
// Usage:
//   Events enter on the input channel (in_valid/in_ready) with kind, ack_flag
//   and ack_seq. Each accepted beat yields exactly one result beat on the
//   output channel (out_valid/out_ready) carrying action, seq_out and
//   lost_count, in event order.
//   The tolerance register is written through cfg_we/cfg_wdata, one cycle,
//   no handshake; write it only while no event is in flight.
// Pipeline and throughput:
//   An event is held in the input register while the core decides it; the
//   decision is then loaded into the result register, which drives the
//   result beat. One event per cycle is sustained while out_ready stays high;
//   the lost count is kept as a running counter so each decision is one add
//   and one compare.
// Stall behaviour:
//   While the receiver holds out_ready low, one further event is still taken
//   into the input register; after that in_ready drops until the result
//   beat is taken.
// Reset:
//   rst_n clears both channel stages, the sequence bits and the waiting flag,
//   marks every window slot received and loads the tolerance of four.
`default_nettype none

module partial_reliability_arq_sender_unit #(
    parameter int WINDOW = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [prarq_pkg::LOST_W-1:0] cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   kind,
    input  wire logic                         ack_flag,
    input  wire logic                         ack_seq,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [prarq_pkg::ACTION_W-1:0]    action,
    output logic                              seq_out,
    output logic [prarq_pkg::LOST_W-1:0]      lost_count
);
    import prarq_pkg::*;

    // input stage
    logic       s1_valid_reg;
    logic [1:0] s1_kind_reg;
    logic       s1_ack_flag_reg;
    logic       s1_ack_seq_reg;

    logic    fire;
    logic    can_load;
    result_t core_res;
    result_t out_res;

    // decide the held event only when the result register can take it
    assign fire     = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload needs no reset: qualified by s1_valid_reg
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg     <= kind;
            s1_ack_flag_reg <= ack_flag;
            s1_ack_seq_reg  <= ack_seq;
        end
    end

    prarq_core #(
        .WINDOW (WINDOW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .kind      (s1_kind_reg),
        .ack_flag  (s1_ack_flag_reg),
        .ack_seq   (s1_ack_seq_reg),
        .res       (core_res)
    );

    prarq_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_valid_reg),
        .res_in    (core_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (out_res)
    );

    // drive the result beat fields
    assign action     = out_res.action;
    assign seq_out    = out_res.seq;
    assign lost_count = out_res.lost;

endmodule : partial_reliability_arq_sender_unit

`default_nettype wire

// File: hdl/prarq_checker.sv
// Port-level checker for the ARQ sender, bound to the top level.
// Depends on prarq_pkg and partial_reliability_arq_sender_unit.
`default_nettype none

module prarq_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [prarq_pkg::ACTION_W-1:0] action,
    input wire logic                         seq_out,
    input wire logic [prarq_pkg::LOST_W-1:0] lost_count
);
    import prarq_pkg::*;

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(seq_out) && $stable(lost_count))
    else $error("result beat changed while stalled");

    // only transmit and retransmit carry a sequence bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_TRANSMIT) && (action != ACT_RETRANSMIT)
            |-> !seq_out)
    else $error("sequence bit set on a beat that sends nothing");

    // a retransmit happens only when some slot is lost
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_RETRANSMIT) |-> (lost_count != '0))
    else $error("retransmit with an empty loss count");

    // a fresh result beat follows an event accepted into the input register and then loaded into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a preceding event");

endmodule : prarq_checker

bind partial_reliability_arq_sender_unit prarq_checker u_prarq_checker (.*);

`default_nettype wire
